[hdl/rsh3_pkg.sv]
// Shared types, constants and the Q.30 multiply for the real spherical harmonic evaluator.
// No dependencies; used by every module of the block.
`default_nettype none

package rsh3_pkg;

    // Pipeline depths of the square root and the divider units.
    localparam int SQ_STAGES  = 32;
    localparam int DIV_STAGES = 32;

    // Working fixed-point word, Q.30 with headroom for the polynomial terms.
    typedef logic signed [35:0] fx_t;

    localparam fx_t ONE_Q30 = 36'sd1073741824;

    // Harmonic normalization constants, round(K * 2^30).
    localparam fx_t K00  = 36'sd302896976;
    localparam fx_t K1   = 36'sd524632952;
    localparam fx_t K2A  = 36'sd1173114945;
    localparam fx_t K20  = 36'sd338649115;
    localparam fx_t K22  = 36'sd586557472;
    localparam fx_t K33  = 36'sd633554480;
    localparam fx_t K3M2 = 36'sd3103770403;
    localparam fx_t K31  = 36'sd490749190;
    localparam fx_t K30  = 36'sd400695036;
    localparam fx_t K3P2 = 36'sd1551885201;

    // Side information that travels with a request through the front end.
    typedef struct packed {
        logic [1:0]        degree;
        logic signed [2:0] order;
        logic              zero;
        logic [2:0]        neg;
        logic [31:0]       mag_x;
        logic [31:0]       mag_y;
        logic [31:0]       mag_z;
        logic [4:0]        shift;
    } side_t;

    // Side information kept for the polynomial stages.
    typedef struct packed {
        logic [1:0]        degree;
        logic signed [2:0] order;
        logic              zero;
    } tail_t;

    // Product in Q.30, rounded to nearest with ties away from zero.
    function automatic fx_t mul30(input fx_t a, input fx_t b);
        logic [35:0] ma;
        logic [35:0] mb;
        logic [71:0] prod;
        logic [71:0] rnd;
        logic        neg;
        begin
            neg  = a[35] ^ b[35];
            ma   = a[35] ? 36'(-a) : 36'(a);
            mb   = b[35] ? 36'(-b) : 36'(b);
            prod = 72'(ma) * 72'(mb);
            rnd  = (prod + (72'd1 << 29)) >> 30;
            mul30 = neg ? -fx_t'(rnd[35:0]) : fx_t'(rnd[35:0]);
        end
    endfunction

endpackage

`default_nettype wire

[hdl/rsh3_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on rsh3_pkg for the stage count.
`default_nettype none

module rsh3_sqrt
    import rsh3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);

    logic [32:0] rem_reg  [SQ_STAGES];
    logic [31:0] root_reg [SQ_STAGES];
    logic [63:0] src_reg  [SQ_STAGES];
    logic [32:0] rem_next  [SQ_STAGES];
    logic [31:0] root_next [SQ_STAGES];
    logic [63:0] src_next  [SQ_STAGES];

    // Each stage brings down two radicand bits and decides one root bit.
    always_comb
    begin
        logic [32:0] rem_p;
        logic [31:0] root_p;
        logic [63:0] src_p;
        logic [33:0] t;
        logic [33:0] trial;
        for (int i = 0; i < SQ_STAGES; i++)
        begin
            if (i == 0)
            begin
                rem_p  = '0;
                root_p = '0;
                src_p  = radicand;
            end
            else
            begin
                rem_p  = rem_reg[i-1];
                root_p = root_reg[i-1];
                src_p  = src_reg[i-1];
            end
            t     = {rem_p[31:0], src_p[63:62]};
            trial = {root_p, 2'b01};
            if (t >= trial)
            begin
                rem_next[i]  = 33'(t - trial);
                root_next[i] = {root_p[30:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = t[32:0];
                root_next[i] = {root_p[30:0], 1'b0};
            end
            src_next[i] = {src_p[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                src_reg[i]  <= src_next[i];
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

`default_nettype wire

[hdl/rsh3_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rsh3_pkg for the stage count.
`default_nettype none

module rsh3_div
    import rsh3_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] rem_in,
    input  wire logic [31:0] low_in,
    input  wire logic [31:0] divisor,
    output logic      [31:0] quotient
);

    logic [31:0] rem_reg [DIV_STAGES];
    logic [31:0] low_reg [DIV_STAGES];
    logic [31:0] dvs_reg [DIV_STAGES];
    logic [31:0] quo_reg [DIV_STAGES];
    logic [31:0] rem_next [DIV_STAGES];
    logic [31:0] low_next [DIV_STAGES];
    logic [31:0] dvs_next [DIV_STAGES];
    logic [31:0] quo_next [DIV_STAGES];

    // Each stage brings down one dividend bit and does one trial subtract.
    always_comb
    begin
        logic [31:0] rem_p;
        logic [31:0] low_p;
        logic [31:0] dvs_p;
        logic [31:0] quo_p;
        logic [32:0] t;
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            if (i == 0)
            begin
                rem_p = rem_in;
                low_p = low_in;
                dvs_p = divisor;
                quo_p = '0;
            end
            else
            begin
                rem_p = rem_reg[i-1];
                low_p = low_reg[i-1];
                dvs_p = dvs_reg[i-1];
                quo_p = quo_reg[i-1];
            end
            t = {rem_p, low_p[31]};
            if (t >= {1'b0, dvs_p})
            begin
                rem_next[i] = 32'(t - {1'b0, dvs_p});
                quo_next[i] = {quo_p[30:0], 1'b1};
            end
            else
            begin
                rem_next[i] = t[31:0];
                quo_next[i] = {quo_p[30:0], 1'b0};
            end
            low_next[i] = {low_p[30:0], 1'b0};
            dvs_next[i] = dvs_p;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                rem_reg[i] <= rem_next[i];
                low_reg[i] <= low_next[i];
                dvs_reg[i] <= dvs_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    assign quotient = quo_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

[hdl/real_spherical_harmonic_l3.sv]
// Top level of the real spherical harmonic evaluator, degrees zero to three.
// Depends on rsh3_pkg, rsh3_sqrt and rsh3_div.
//
// The block takes one request per clock while in_stall is low and returns one Q1.30 value per request, in order.
// The pipeline has 75 register stages, the first of which loads at the accepting edge:
// five front-end stages (input, squares, sum, two normalize steps), a 32-stage square root, a
// numerator stage, three parallel 32-stage dividers that scale the vector to unit length, and
// five polynomial stages. A two-entry output (final register plus a skid register) catches a
// final result that meets out_stall in the skid register so the pipeline can still advance; in_stall
// is high whenever the skid register holds a result. The block keeps no state between requests.
`default_nettype none

module real_spherical_harmonic_l3
    import rsh3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         degree,
    input  wire logic signed [2:0]  order,
    input  wire logic signed [31:0] vec_x,
    input  wire logic signed [31:0] vec_y,
    input  wire logic signed [31:0] vec_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      harmonic_value
);

    logic en;
    logic skid_valid_reg;
    logic signed [31:0] skid_value_reg;

    // The whole pipeline moves unless the skid register is holding a result.
    assign en       = ~skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // Front end: input capture, squares, sum, normalize.
    logic  v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    side_t s0_reg, s1_reg, s2_reg, s3_reg, s4_reg;
    logic [63:0] sqx_reg, sqy_reg, sqz_reg;
    logic [63:0] sum_reg, norm3_reg, norm4_reg;
    side_t s0_next;
    side_t s3_next, s4_next;
    logic [63:0] norm3_next, norm4_next;
    logic [4:0]  shift3_next, shift4_next;

    // Magnitudes and signs of the incoming vector.
    always_comb
    begin
        s0_next        = '0;
        s0_next.degree = degree;
        s0_next.order  = order;
        s0_next.neg    = {vec_z[31], vec_y[31], vec_x[31]};
        s0_next.mag_x  = vec_x[31] ? 32'(-vec_x) : 32'(vec_x);
        s0_next.mag_y  = vec_y[31] ? 32'(-vec_y) : 32'(vec_y);
        s0_next.mag_z  = vec_z[31] ? 32'(-vec_z) : 32'(vec_z);
    end

    // First normalize step: shifts of 32 and 16 bits.
    always_comb
    begin
        logic [63:0] t;
        t           = sum_reg;
        shift3_next = '0;
        if (t[63:32] == '0)
        begin
            t = t << 32;
            shift3_next[4] = 1'b1;
        end
        if (t[63:48] == '0)
        begin
            t = t << 16;
            shift3_next[3] = 1'b1;
        end
        norm3_next    = t;
        s3_next       = s2_reg;
        s3_next.zero  = (sum_reg == '0);
        s3_next.shift = shift3_next;
    end

    // Second normalize step: shifts of 8, 4 and 2 bits.
    always_comb
    begin
        logic [63:0] t;
        t           = norm3_reg;
        shift4_next = s3_reg.shift;
        if (t[63:56] == '0)
        begin
            t = t << 8;
            shift4_next[2] = 1'b1;
        end
        if (t[63:60] == '0)
        begin
            t = t << 4;
            shift4_next[1] = 1'b1;
        end
        if (t[63:62] == '0)
        begin
            t = t << 2;
            shift4_next[0] = 1'b1;
        end
        norm4_next    = t;
        s4_next       = s3_reg;
        s4_next.shift = shift4_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg  <= s0_next;
            s1_reg  <= s0_reg;
            sqx_reg <= 64'(s0_reg.mag_x) * 64'(s0_reg.mag_x);
            sqy_reg <= 64'(s0_reg.mag_y) * 64'(s0_reg.mag_y);
            sqz_reg <= 64'(s0_reg.mag_z) * 64'(s0_reg.mag_z);
            s2_reg  <= s1_reg;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
            s3_reg    <= s3_next;
            norm3_reg <= norm3_next;
            s4_reg    <= s4_next;
            norm4_reg <= norm4_next;
        end
    end

    // Square root of the normalized sum, with side data delayed alongside.
    logic [31:0] root;
    logic  vsq_reg [SQ_STAGES];
    side_t ssq_reg [SQ_STAGES];

    rsh3_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (norm4_reg),
        .root     (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQ_STAGES; i++)
            begin
                vsq_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vsq_reg[0] <= v4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                vsq_reg[i] <= vsq_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ssq_reg[0] <= s4_reg;
            for (int i = 1; i < SQ_STAGES; i++)
            begin
                ssq_reg[i] <= ssq_reg[i-1];
            end
        end
    end

    // Numerators (mag << h << 30) + q/2, split into the starting remainder and the low bits.
    side_t sq_side;
    logic [93:0] num_x, num_y, num_z;
    logic        v5_reg;
    tail_t       t5_reg;
    logic [2:0]  n5_reg;
    logic [31:0] q5_reg;
    logic [31:0] remx5_reg, remy5_reg, remz5_reg;
    logic [31:0] lowx5_reg, lowy5_reg, lowz5_reg;

    assign sq_side = ssq_reg[SQ_STAGES-1];

    always_comb
    begin
        num_x = ((94'(sq_side.mag_x) << sq_side.shift) << 30) + 94'(root >> 1);
        num_y = ((94'(sq_side.mag_y) << sq_side.shift) << 30) + 94'(root >> 1);
        num_z = ((94'(sq_side.mag_z) << sq_side.shift) << 30) + 94'(root >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= vsq_reg[SQ_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_reg    <= '{degree: sq_side.degree, order: sq_side.order, zero: sq_side.zero};
            n5_reg    <= sq_side.neg;
            q5_reg    <= root;
            remx5_reg <= num_x[63:32];
            remy5_reg <= num_y[63:32];
            remz5_reg <= num_z[63:32];
            lowx5_reg <= num_x[31:0];
            lowy5_reg <= num_y[31:0];
            lowz5_reg <= num_z[31:0];
        end
    end

    // Three dividers give the unit vector magnitudes.
    logic [31:0] quo_x, quo_y, quo_z;
    logic  vdv_reg [DIV_STAGES];
    tail_t tdv_reg [DIV_STAGES];
    logic [2:0] ndv_reg [DIV_STAGES];

    rsh3_div u_div_x (
        .clk      (clk),
        .en       (en),
        .rem_in   (remx5_reg),
        .low_in   (lowx5_reg),
        .divisor  (q5_reg),
        .quotient (quo_x)
    );

    rsh3_div u_div_y (
        .clk      (clk),
        .en       (en),
        .rem_in   (remy5_reg),
        .low_in   (lowy5_reg),
        .divisor  (q5_reg),
        .quotient (quo_y)
    );

    rsh3_div u_div_z (
        .clk      (clk),
        .en       (en),
        .rem_in   (remz5_reg),
        .low_in   (lowz5_reg),
        .divisor  (q5_reg),
        .quotient (quo_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vdv_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vdv_reg[0] <= v5_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vdv_reg[i] <= vdv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tdv_reg[0] <= t5_reg;
            ndv_reg[0] <= n5_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                tdv_reg[i] <= tdv_reg[i-1];
                ndv_reg[i] <= ndv_reg[i-1];
            end
        end
    end

    // Polynomial back end.
    logic       v6_reg, v7_reg, v8_reg, v9_reg, r_valid_reg;
    tail_t      t6_reg, t7_reg, t8_reg, t9_reg, r_tail_reg;
    fx_t        ux6_reg, uy6_reg, uz6_reg;
    fx_t        ux7_reg, uy7_reg, uz7_reg;
    fx_t        xx7_reg, yy7_reg, zz7_reg, xy7_reg, yz7_reg, xz7_reg;
    fx_t        ka8_reg, pa8_reg, pb8_reg, pd8_reg;
    logic       mul8_reg;
    fx_t        k9_reg, p9_reg;
    logic signed [31:0] r_value_reg;
    fx_t        ux6_next, uy6_next, uz6_next;
    fx_t        k8_next, a8_next, b8_next, d8_next;
    logic       mul8_next;
    fx_t        v_full;
    logic signed [31:0] r_value_next;
    logic [2:0] dv_neg;

    assign dv_neg = ndv_reg[DIV_STAGES-1];

    // Cap each magnitude at one and restore the component sign.
    function automatic fx_t to_unit(input logic [31:0] q, input logic neg);
        fx_t u;
        begin
            u = (36'(q) > ONE_Q30) ? ONE_Q30 : fx_t'(36'(q));
            to_unit = neg ? -u : u;
        end
    endfunction

    always_comb
    begin
        ux6_next = to_unit(quo_x, dv_neg[0]);
        uy6_next = to_unit(quo_y, dv_neg[1]);
        uz6_next = to_unit(quo_z, dv_neg[2]);
    end

    // Choose the constant and either a direct term or the operands of a second multiply.
    always_comb
    begin
        fx_t t3xy;
        fx_t t5z1;
        fx_t t5z3;
        fx_t xmy;
        fx_t x3y;
        t3xy      = 36'(3 * xx7_reg) - yy7_reg;
        t5z1      = 36'(5 * zz7_reg) - ONE_Q30;
        t5z3      = 36'(5 * zz7_reg) - 36'(3 * ONE_Q30);
        xmy       = xx7_reg - yy7_reg;
        x3y       = xx7_reg - 36'(3 * yy7_reg);
        k8_next   = '0;
        a8_next   = '0;
        b8_next   = '0;
        d8_next   = '0;
        mul8_next = 1'b0;
        case (t7_reg.degree)
            2'd1:
            begin
                k8_next = K1;
                case (t7_reg.order)
                    -3'sd1:  d8_next = uy7_reg;
                    3'sd0:   d8_next = uz7_reg;
                    3'sd1:   d8_next = ux7_reg;
                    default: d8_next = '0;
                endcase
            end
            2'd2:
            begin
                case (t7_reg.order)
                    -3'sd2:
                    begin
                        k8_next = K2A;
                        d8_next = xy7_reg;
                    end
                    -3'sd1:
                    begin
                        k8_next = K2A;
                        d8_next = yz7_reg;
                    end
                    3'sd0:
                    begin
                        k8_next = K20;
                        d8_next = 36'(3 * zz7_reg) - ONE_Q30;
                    end
                    3'sd1:
                    begin
                        k8_next = K2A;
                        d8_next = xz7_reg;
                    end
                    3'sd2:
                    begin
                        k8_next = K22;
                        d8_next = xmy;
                    end
                    default:
                    begin
                        k8_next = '0;
                    end
                endcase
            end
            2'd3:
            begin
                mul8_next = 1'b1;
                case (t7_reg.order)
                    -3'sd3:
                    begin
                        k8_next = K33;
                        a8_next = uy7_reg;
                        b8_next = t3xy;
                    end
                    -3'sd2:
                    begin
                        k8_next = K3M2;
                        a8_next = xy7_reg;
                        b8_next = uz7_reg;
                    end
                    -3'sd1:
                    begin
                        k8_next = K31;
                        a8_next = uy7_reg;
                        b8_next = t5z1;
                    end
                    3'sd0:
                    begin
                        k8_next = K30;
                        a8_next = uz7_reg;
                        b8_next = t5z3;
                    end
                    3'sd1:
                    begin
                        k8_next = K31;
                        a8_next = ux7_reg;
                        b8_next = t5z1;
                    end
                    3'sd2:
                    begin
                        k8_next = K3P2;
                        a8_next = xmy;
                        b8_next = uz7_reg;
                    end
                    3'sd3:
                    begin
                        k8_next = K33;
                        a8_next = ux7_reg;
                        b8_next = x3y;
                    end
                    default:
                    begin
                        k8_next = '0;
                    end
                endcase
            end
            default:
            begin
                k8_next = '0;
            end
        endcase
    end

    // Final scale, saturation and the degree-zero and zero-vector cases.
    always_comb
    begin
        v_full = mul30(k9_reg, p9_reg);
        if (v_full > 36'sd2147483647)
        begin
            r_value_next = 32'sh7FFFFFFF;
        end
        else if (v_full < -36'sd2147483648)
        begin
            r_value_next = 32'sh80000000;
        end
        else
        begin
            r_value_next = 32'(v_full);
        end
        if (t9_reg.degree == 2'd0)
        begin
            r_value_next = (t9_reg.order == 3'sd0) ? 32'(K00) : '0;
        end
        else if (t9_reg.zero)
        begin
            r_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            v8_reg      <= 1'b0;
            v9_reg      <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg      <= vdv_reg[DIV_STAGES-1];
            v7_reg      <= v6_reg;
            v8_reg      <= v7_reg;
            v9_reg      <= v8_reg;
            r_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t6_reg   <= tdv_reg[DIV_STAGES-1];
            ux6_reg  <= ux6_next;
            uy6_reg  <= uy6_next;
            uz6_reg  <= uz6_next;
            t7_reg   <= t6_reg;
            ux7_reg  <= ux6_reg;
            uy7_reg  <= uy6_reg;
            uz7_reg  <= uz6_reg;
            xx7_reg  <= mul30(ux6_reg, ux6_reg);
            yy7_reg  <= mul30(uy6_reg, uy6_reg);
            zz7_reg  <= mul30(uz6_reg, uz6_reg);
            xy7_reg  <= mul30(ux6_reg, uy6_reg);
            yz7_reg  <= mul30(uy6_reg, uz6_reg);
            xz7_reg  <= mul30(ux6_reg, uz6_reg);
            t8_reg   <= t7_reg;
            ka8_reg  <= k8_next;
            pa8_reg  <= a8_next;
            pb8_reg  <= b8_next;
            pd8_reg  <= d8_next;
            mul8_reg <= mul8_next;
            t9_reg   <= t8_reg;
            k9_reg   <= ka8_reg;
            p9_reg   <= mul8_reg ? mul30(pa8_reg, pb8_reg) : pd8_reg;
            r_tail_reg  <= t9_reg;
            r_value_reg <= r_value_next;
        end
    end

    // Skid register catches the final result when the output is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (r_valid_reg && out_stall)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && r_valid_reg && out_stall)
        begin
            skid_value_reg <= r_value_reg;
        end
    end

    assign out_valid      = skid_valid_reg | r_valid_reg;
    assign harmonic_value = skid_valid_reg ? skid_value_reg : r_value_reg;

    // The skid register only fills from a stalled final result.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(r_valid_reg && out_stall))
        else $error("skid register filled without a stalled result");

    // Degree zero with a nonzero order always yields zero.
    a_deg0_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && r_tail_reg.degree == 2'd0 && r_tail_reg.order != 3'sd0)
        |-> (r_value_reg == '0))
        else $error("degree zero with nonzero order gave a nonzero value");

    // A zero vector gives zero for every degree above zero.
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && r_tail_reg.zero && r_tail_reg.degree != 2'd0)
        |-> (r_value_reg == '0))
        else $error("zero vector gave a nonzero value");

endmodule

`default_nettype wire
